// ===== rtl/afv_pkg.sv =====
// ----------------------------------------------------------------------------
// afv_pkg
// Shared types and constants for the attractive field velocity unit.
// ----------------------------------------------------------------------------
`default_nettype none
package afv_pkg;
  localparam int unsigned POS_W  = 24;
  localparam int unsigned MAG_W  = 25;
  localparam int unsigned SQ_W   = 52;
  localparam int unsigned DIST_W = 26;
  localparam int unsigned VEL_W  = 24;
  localparam int unsigned CFG_W  = 24;
  localparam int unsigned QUO_W  = 50;
  localparam int unsigned NUM_W  = 49;

  typedef enum logic [1:0] {
    ZONE_DEAD = 2'd0,
    ZONE_NEAR = 2'd1,
    ZONE_FAR  = 2'd2
  } zone_t;

  typedef enum logic [1:0] {
    REG_SCALE  = 2'd0,
    REG_DEAD   = 2'd1,
    REG_RADIUS = 2'd2
  } reg_idx_t;

  localparam logic [7:0] CHARGE_ATTRACT = 8'd1;
endpackage
`default_nettype wire

// ===== rtl/attractive_field_velocity_unit.sv =====
// ----------------------------------------------------------------------------
// attractive_field_velocity_unit
// Pipelined attractive potential-field velocity: per-axis differences, sum of
// squares, restoring square root one result bit per stage, then three
// restoring dividers one quotient bit per stage for the far zone.
// ----------------------------------------------------------------------------
// Channel | Dir | Signals                       | Payload
// s_axis  | in  | s_axis_tvalid/tready/tdata    | cur xyz, goal xyz, charge
// m_axis  | out | m_axis_tvalid/tready/tdata    | vel xyz, distance, zone
// apb     | in  | psel penable pwrite paddr ... | scale, dead, radius
//
// One item per cycle while m_axis is not stalled. The pipe runs through stages A, B,
// C, root, zone, numerator, divide and the output register; root and divide are bit-serial.
// Items with charge other than 1 travel as bubbles and produce no result.
// A stall on m_axis freezes the whole pipe; s_axis_tready follows the
// output register's state, so nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module attractive_field_velocity_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // cur_x[23:0] cur_y[47:24] cur_z[71:48] goal_x[95:72] goal_y[119:96]
  // goal_z[143:120] goal_charge[151:144]
  input  wire logic [151:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // vel_x[23:0] vel_y[47:24] vel_z[71:48] distance[96:72] zone[98:97], pad 0
  output logic [103:0]     m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import afv_pkg::*;

  localparam logic [CFG_W-1:0] SCALE_RST  = CFG_W'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic [CFG_W-1:0] DEAD_RST   = CFG_W'(((1 << FRAC_BITS) * 15 + 500) / 1000);
  localparam logic [CFG_W-1:0] RADIUS_RST = CFG_W'(((1 << FRAC_BITS) + 5) / 10);
  localparam int unsigned RS = DIST_W;   // root stages
  localparam int unsigned DS = NUM_W;    // divide stages

  // ---------------- configuration registers
  logic [CFG_W-1:0] scale_factor, dead_threshold, field_radius;
  reg_idx_t         cfg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor   <= SCALE_RST;
      dead_threshold <= DEAD_RST;
      field_radius   <= RADIUS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SCALE:  scale_factor   <= pwdata[CFG_W-1:0];
        REG_DEAD:   dead_threshold <= pwdata[CFG_W-1:0];
        REG_RADIUS: field_radius   <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SCALE:  prdata = {8'd0, scale_factor};
      REG_DEAD:   prdata = {8'd0, dead_threshold};
      REG_RADIUS: prdata = {8'd0, field_radius};
      default:    prdata = 32'd0;
    endcase
  end

  // ---------------- global pipeline advance
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------- stage A: absolute differences
  logic             a_vld;
  logic [MAG_W-1:0] a_mag [3];
  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (adv) a_vld <= s_axis_tvalid && (s_axis_tdata[151:144] == CHARGE_ATTRACT);
  end
  for (genvar i = 0; i < 3; i++) begin : g_diff
    logic signed [MAG_W-1:0] d;
    assign d = MAG_W'($signed(s_axis_tdata[24*i +: 24]))
             - MAG_W'($signed(s_axis_tdata[72 + 24*i +: 24]));
    always_ff @(posedge clk) if (adv) a_mag[i] <= d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
  end

  // ---------------- stage B: squares
  logic             b_vld;
  logic [MAG_W-1:0] b_mag [3];
  logic [49:0]      b_sq  [3];
  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (adv) b_vld <= a_vld;
  end
  for (genvar i = 0; i < 3; i++) begin : g_sq
    always_ff @(posedge clk) if (adv) begin
      b_mag[i] <= a_mag[i];
      b_sq[i]  <= 50'(a_mag[i]) * 50'(a_mag[i]);
    end
  end

  // ---------------- stage C: sum of squares
  logic             c_vld;
  logic [MAG_W-1:0] c_mag [3];
  logic [SQ_W-1:0]  c_sum;
  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else if (adv) c_vld <= b_vld;
    if (adv) begin
      c_mag <= b_mag;
      c_sum <= SQ_W'(b_sq[0]) + SQ_W'(b_sq[1]) + SQ_W'(b_sq[2]);
    end
  end

  // ---------------- square root: one result bit per stage
  logic             r_vld [RS+1];
  logic [SQ_W-1:0]  r_rem [RS+1];
  logic [DIST_W-1:0] r_root [RS+1];
  logic [MAG_W-1:0] r_mag [RS+1][3];
  assign r_vld[0]  = c_vld;
  assign r_rem[0]  = c_sum;
  assign r_root[0] = '0;
  assign r_mag[0]  = c_mag;
  for (genvar k = 0; k < RS; k++) begin : g_root
    localparam int unsigned B = RS - 1 - k;
    logic            trial;
    logic [SQ_W+1:0] sq;
    // growth of the square when bit B is set: (2*root + 2^B) * 2^B
    assign sq    = ((SQ_W+2)'(r_root[k]) << (B + 1)) | ((SQ_W+2)'(1) << (2 * B));
    assign trial = (SQ_W+2)'(r_rem[k]) >= sq;
    always_ff @(posedge clk) begin
      if (rst) r_vld[k+1] <= 1'b0;
      else if (adv) r_vld[k+1] <= r_vld[k];
      if (adv) begin
        r_mag[k+1] <= r_mag[k];
        if (trial) begin
          r_rem[k+1]  <= r_rem[k] - SQ_W'(sq);
          r_root[k+1] <= r_root[k] | (DIST_W'(1) << B);
        end else begin
          r_rem[k+1]  <= r_rem[k];
          r_root[k+1] <= r_root[k];
        end
      end
    end
  end

  // ---------------- zone decision
  logic             z_vld;
  logic [MAG_W-1:0] z_mag [3];
  logic [DIST_W-2:0] z_dist;
  zone_t            z_zone;
  logic [DIST_W-2:0] root25;
  assign root25 = r_root[RS][DIST_W-2:0];
  always_ff @(posedge clk) begin
    if (rst) z_vld <= 1'b0;
    else if (adv) z_vld <= r_vld[RS];
    if (adv) begin
      z_mag  <= r_mag[RS];
      z_dist <= root25;
      if (root25 < (DIST_W-1)'(dead_threshold))    z_zone <= ZONE_DEAD;
      else if (root25 < (DIST_W-1)'(field_radius)) z_zone <= ZONE_NEAR;
      else                                          z_zone <= ZONE_FAR;
    end
  end

  // ---------------- numerator: scale * |d|
  logic             n_vld;
  logic [MAG_W-1:0] n_mag [3];
  logic [NUM_W-1:0] n_num [3];
  logic [DIST_W-2:0] n_dist;
  zone_t            n_zone;
  always_ff @(posedge clk) begin
    if (rst) n_vld <= 1'b0;
    else if (adv) n_vld <= z_vld;
    if (adv) begin
      n_mag  <= z_mag;
      n_dist <= z_dist;
      n_zone <= z_zone;
      for (int i = 0; i < 3; i++) n_num[i] <= NUM_W'(scale_factor) * NUM_W'(z_mag[i]);
    end
  end

  // ---------------- restoring divider: one quotient bit per stage
  logic              q_vld  [DS+1];
  logic [DIST_W-1:0] q_rem  [DS+1][3];
  logic [NUM_W-1:0]  q_num  [DS+1][3];
  logic [MAG_W-1:0]  q_mag  [DS+1][3];
  logic [DIST_W-2:0] q_dist [DS+1];
  zone_t             q_zone [DS+1];
  assign q_vld[0]  = n_vld;
  assign q_num[0]  = n_num;
  assign q_mag[0]  = n_mag;
  assign q_dist[0] = n_dist;
  assign q_zone[0] = n_zone;
  for (genvar i = 0; i < 3; i++) begin : g_r0
    assign q_rem[0][i] = '0;
  end
  for (genvar k = 0; k < DS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) q_vld[k+1] <= 1'b0;
      else if (adv) q_vld[k+1] <= q_vld[k];
      if (adv) begin
        q_mag[k+1]  <= q_mag[k];
        q_dist[k+1] <= q_dist[k];
        q_zone[k+1] <= q_zone[k];
        for (int i = 0; i < 3; i++) begin
          logic [DIST_W:0] sh;
          sh = {q_rem[k][i], q_num[k][i][NUM_W-1]};
          if (sh >= (DIST_W+1)'(q_dist[k])) begin
            q_rem[k+1][i] <= DIST_W'(sh - (DIST_W+1)'(q_dist[k]));
            q_num[k+1][i] <= {q_num[k][i][NUM_W-2:0], 1'b1};
          end else begin
            q_rem[k+1][i] <= DIST_W'(sh);
            q_num[k+1][i] <= {q_num[k][i][NUM_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // ---------------- output register
  logic [VEL_W-1:0] vel [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (q_zone[DS])
        ZONE_DEAD: vel[i] = '0;
        ZONE_NEAR: vel[i] = q_mag[DS][i][MAG_W-1] ? '1 : q_mag[DS][i][VEL_W-1:0];
        ZONE_FAR: begin
          if (q_dist[DS] == '0)                      vel[i] = '0;
          else if (|q_num[DS][i][NUM_W-1:VEL_W])     vel[i] = '1;
          else                                        vel[i] = q_num[DS][i][VEL_W-1:0];
        end
        default: vel[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= q_vld[DS];
    if (adv && q_vld[DS])
      m_axis_tdata <= {5'd0, q_zone[DS], q_dist[DS], vel[2], vel[1], vel[0]};
  end

  // ---------------- assertions
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready mismatch");
  a_zone: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[98:97] != 2'd3)
    else $error("bad zone code");
  a_dead: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[98:97] == 2'd0 |-> m_axis_tdata[71:0] == 72'd0)
    else $error("dead zone velocity not zero");
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Attractive field velocity unit testbench
// Drives position/goal items with random gaps and output stalls, predicts the
// velocity, distance and zone of each attracting item in a local model, and
// compares every result item field by field. Register settings change between
// phases while the pipe is drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import afv_pkg::*;

  localparam int PIPE_LAT = 90;

  logic          clk;
  logic          rst;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [151:0]  s_axis_tdata;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [103:0]  m_axis_tdata;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [3:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  // Result item, fields from the top bit down (vel_x in the lowest bits)
  typedef struct packed {
    zone_t       zone;
    logic [24:0] distance;
    logic [23:0] vz;
    logic [23:0] vy;
    logic [23:0] vx;
  } vel_res_t;

  // One directed row: position item plus optional typed-in result
  typedef struct {
    logic [151:0] data;
    bit           fixed;
    vel_res_t     res;
  } row_t;

  vel_res_t      vel_q[$];
  logic [23:0]   gain_r;
  logic [23:0]   dead_r;
  logic [23:0]   radius_r;
  bit            failed;
  bit            long_stall;

  attractive_field_velocity_unit u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Velocity, distance and zone for one attracting item
  function automatic vel_res_t attract_vel(input logic [151:0] d);
    logic signed [24:0] df;
    logic [24:0]        mag[3];
    logic [63:0]        sum;
    logic [63:0]        q;
    logic [24:0]        dist_v;
    logic [23:0]        v[3];
    vel_res_t           r;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      df = $signed(d[24*i +: 24]) - $signed(d[24*(i+3) +: 24]);
      mag[i] = df < 0 ? -df : df;
      sum += 64'(mag[i]) * 64'(mag[i]);
    end
    dist_v = 25'(root64(sum));
    for (int i = 0; i < 3; i++) begin
      if (dist_v < dead_r) begin
        v[i] = 0;
      end else if (dist_v < radius_r) begin
        v[i] = mag[i] > 25'hFFFFFF ? 24'hFFFFFF : mag[i][23:0];
      end else if (dist_v == 0) begin
        v[i] = 0;
      end else begin
        q = (64'(gain_r) * 64'(mag[i])) / 64'(dist_v);
        v[i] = q > 64'hFFFFFF ? 24'hFFFFFF : q[23:0];
      end
    end
    r.vx = v[0];
    r.vy = v[1];
    r.vz = v[2];
    r.distance = dist_v;
    r.zone = dist_v < dead_r ? ZONE_DEAD : dist_v < radius_r ? ZONE_NEAR : ZONE_FAR;
    return r;
  endfunction

  function automatic logic [151:0] pack_item(input logic [23:0] cx, cy, cz,
                                             input logic [23:0] gx, gy, gz,
                                             input logic [7:0] ch);
    return {ch, gz, gy, gx, cz, cy, cx};
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 2))
                                      : int'($urandom_range(3, 30));
  endfunction

  task automatic reg_write(input reg_idx_t idx, input logic [23:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx) << 2;
    pwdata  <= {8'($urandom_range(0, 255)), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SCALE:  gain_r   = val;
      REG_DEAD:   dead_r   = val;
      default:    radius_r = val;
    endcase
  endtask

  // Send one item, hold valid until accepted
  task automatic send_item(input logic [151:0] d, input int gap);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (d[151:144] == CHARGE_ATTRACT) vel_q.push_back(attract_vel(d));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (vel_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  function automatic logic [23:0] rnd_pos(input logic [23:0] base, input int span);
    case ($urandom_range(0, 3))
      0:       return 24'($urandom());
      1:       return base + 24'($urandom_range(0, 2 * span) - span);
      2:       return base + 24'($urandom_range(0, 64) - 32);
      default: return base + 24'($urandom_range(0, 16 * span) - 8 * span);
    endcase
  endfunction

  task automatic random_phase(input int n, input bit dense);
    logic [23:0] c[3];
    logic [23:0] g[3];
    logic [7:0]  ch;
    int          span;
    for (int k = 0; k < n; k++) begin
      span = radius_r == 0 ? 64 : int'(radius_r);
      if (span > 1 << 20) span = 1 << 20;
      for (int i = 0; i < 3; i++) begin
        c[i] = 24'($urandom());
        g[i] = rnd_pos(c[i], span);
      end
      ch = ($urandom_range(0, 9) < 8) ? CHARGE_ATTRACT : 8'($urandom());
      send_item(pack_item(c[0], c[1], c[2], g[0], g[1], g[2], ch),
                dense ? 0 : gap_len());
    end
  endtask

  // Result checking
  always @(posedge clk) begin
    vel_res_t got;
    vel_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[98:0];
      if (vel_q.size() == 0) begin
        $error("result item with none expected: %h", got);
        failed = 1'b1;
      end else begin
        want = vel_q.pop_front();
        if (got.vx !== want.vx) begin
          $error("vel_x exp %h got %h", want.vx, got.vx); failed = 1'b1;
        end
        if (got.vy !== want.vy) begin
          $error("vel_y exp %h got %h", want.vy, got.vy); failed = 1'b1;
        end
        if (got.vz !== want.vz) begin
          $error("vel_z exp %h got %h", want.vz, got.vz); failed = 1'b1;
        end
        if (got.distance !== want.distance) begin
          $error("distance exp %h got %h", want.distance, got.distance); failed = 1'b1;
        end
        if (got.zone !== want.zone) begin
          $error("zone exp %0d got %0d", want.zone, got.zone); failed = 1'b1;
        end
      end
    end
  end

  // Output stall pattern
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b1;
    end else if (long_stall) begin
      m_axis_tready <= ($urandom_range(0, 9) < 2);
    end else begin
      m_axis_tready <= ($urandom_range(0, 9) < 8);
    end
  end

  // Directed table
  row_t dir_tab[$];

  task automatic build_table();
    row_t r;
    r.fixed = 1'b1;
    // zero distance: dead zone at reset settings
    r.data = pack_item(0, 0, 0, 0, 0, 0, CHARGE_ATTRACT);
    r.res = '{vx: 0, vy: 0, vz: 0, distance: 0, zone: ZONE_DEAD};
    dir_tab.push_back(r);
    // charge not one: no result
    r.data = pack_item(1, 2, 3, 4, 5, 6, 8'd0);
    r.fixed = 1'b0;
    dir_tab.push_back(r);
    r.data = pack_item(1, 2, 3, 4, 5, 6, 8'hFF);
    dir_tab.push_back(r);
    r.data = pack_item(1, 2, 3, 4, 5, 6, 8'hFE);
    dir_tab.push_back(r);
    // near zone: single axis difference 2000
    r.fixed = 1'b1;
    r.data = pack_item(24'd2000, 0, 0, 0, 0, 0, CHARGE_ATTRACT);
    r.res = '{vx: 2000, vy: 0, vz: 0, distance: 2000, zone: ZONE_NEAR};
    dir_tab.push_back(r);
    r.fixed = 1'b0;
    // far zone, zone boundaries and extremes
    r.data = pack_item(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                       24'h800000, 24'h800000, 24'h800000, CHARGE_ATTRACT);
    dir_tab.push_back(r);
    r.data = pack_item(24'h800000, 24'h7FFFFF, 24'h800000,
                       24'h7FFFFF, 24'h800000, 24'h7FFFFF, CHARGE_ATTRACT);
    dir_tab.push_back(r);
    r.data = pack_item(24'h800000, 0, 0, 24'h7FFFFF, 0, 0, CHARGE_ATTRACT);
    dir_tab.push_back(r);
    r.data = pack_item(0, 24'd6554, 0, 0, 0, 0, CHARGE_ATTRACT);
    dir_tab.push_back(r);
    r.data = pack_item(0, 0, 24'd6553, 0, 0, 0, CHARGE_ATTRACT);
    dir_tab.push_back(r);
    r.data = pack_item(0, 0, 24'd983, 0, 0, 0, CHARGE_ATTRACT);
    dir_tab.push_back(r);
    r.data = pack_item(0, 0, 24'd982, 0, 0, 0, CHARGE_ATTRACT);
    dir_tab.push_back(r);
    r.data = pack_item(24'hFFFFFF, 24'h555555, 24'hAAAAAA,
                       24'h000001, 24'hAAAAAA, 24'h555555, CHARGE_ATTRACT);
    dir_tab.push_back(r);
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    failed        = 1'b0;
    long_stall    = 1'b0;
    gain_r        = 24'd6554;
    dead_r        = 24'd983;
    radius_r      = 24'd6554;
    build_table();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].data, 0);
      if (dir_tab[i].fixed) begin
        vel_q.pop_back();
        vel_q.push_back(dir_tab[i].res);
      end
    end
    drain();

    // zero thresholds: far zone at zero distance
    reg_write(REG_DEAD, 24'd0);
    reg_write(REG_RADIUS, 24'd0);
    send_item(pack_item(5, 5, 5, 5, 5, 5, CHARGE_ATTRACT), 0);
    random_phase(100, 1'b0);
    drain();

    // maximum gain and thresholds
    reg_write(REG_SCALE, 24'hFFFFFF);
    reg_write(REG_DEAD, 24'hFFFFFF);
    reg_write(REG_RADIUS, 24'hFFFFFF);
    random_phase(100, 1'b0);
    drain();

    reg_write(REG_DEAD, 24'd0);
    random_phase(150, 1'b1);
    drain();

    reg_write(REG_RADIUS, 24'd1000);
    long_stall = 1'b1;
    random_phase(150, 1'b0);
    drain();
    long_stall = 1'b0;

    // random settings
    for (int p = 0; p < 10; p++) begin
      reg_write(REG_SCALE, 24'($urandom()));
      reg_write(REG_DEAD, 24'($urandom_range(0, 4000)));
      reg_write(REG_RADIUS, 24'($urandom_range(0, 1 << 18)));
      long_stall = (p % 3 == 2);
      random_phase(100, p % 4 == 1);
      drain();
    end

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/afv_pkg.sv
rtl/attractive_field_velocity_unit.sv
verif/tb.sv
